// File: hdl/osb_pkg.sv
// Package for the one-shot timer bank: item codes, result codes and the
// token that walks the cell chain. No dependencies.
package osb_pkg;

   localparam int SLOTS_DEFAULT     = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int SLOT_W    = 4;
   localparam int DELAY_W   = 32;
   localparam int MAX_FIRES = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);
   localparam logic [FIRE_CNT_W-1:0] FIRE_LIMIT = FIRE_CNT_W'(MAX_FIRES);

   typedef enum logic [1:0] {
      KIND_ARM    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_FLUSH  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_ARMED   = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_FIRED   = 2'd2
   } status_type;

   // Control token handed from cell to cell, one hop per cycle while the chain advances.
   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic [SLOT_W-1:0]     slot;
      logic                  claimed;
      logic [SLOT_W-1:0]     claim_id;
      logic [FIRE_CNT_W-1:0] fire_cnt;
   } token_type;

   // Fire report from a cell to the result logic.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] id;
   } emit_type;

endpackage

// File: hdl/osb_if.sv
// Handshake channels for the one-shot timer bank: item and result channels.
// Depends on osb_pkg for field widths.
interface osb_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      kind;
   logic [osb_pkg::SLOT_W-1:0]      slot;
   logic [osb_pkg::DELAY_W-1:0]     delay;

   modport source (output valid, output kind, output slot, output delay, input ready);
   modport sink   (input valid, input kind, input slot, input delay, output ready);
endinterface

interface osb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic [osb_pkg::SLOT_W-1:0]      slot_id;
   logic                            last;

   modport source (output valid, output status, output slot_id, output last, input ready);
   modport sink   (input valid, input status, input slot_id, input last, output ready);
endinterface

// File: hdl/one_shot_timer_bank_top.sv
// Top level of the one-shot timer bank: item intake, time counter, cell chain,
// result sequencing and output register. Depends on osb_pkg, osb_if, osb_cell.
//
// A bank of SLOTS one-shot timers built as a chain of cells, one cell per slot.
// Each accepted item becomes a token that walks the chain one cell per cycle
// while no stalled result holds the chain: arm claims the lowest free slot,
// cancel frees the named slot (numbers at or above SLOTS are ignored), tick
// advances the time counter by one and fires every expired slot in ascending
// order (at most 16 per tick), flush frees expired slots silently. An item
// occupies the block from its transfer until the next item can be taken, set
// by the token walk through the chain and the tail stage. A result that finds
// the output register still holding an earlier result the channel has not
// taken holds the whole chain, so back-pressure on the result channel
// lengthens the item. Arm gives one result with last set; tick gives one
// result per fired slot, last set on the final one; cancel, flush and a tick
// with nothing expired give none. Results leave through a registered output
// stage, so the next item is taken while the final result still waits. No
// clearing pass is needed after reset.
module one_shot_timer_bank_top #(
   parameter int SLOTS     = osb_pkg::SLOTS_DEFAULT,
   parameter int TIME_BITS = osb_pkg::TIME_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   osb_req_if.sink    req_ch,
   osb_rsp_if.source  rsp_ch
);

   // Item intake and shared registers.
   logic                 busy_ff, busy_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] dly_ff, dly_in;
   logic                 accept;

   // Cell chain.
   osb_pkg::token_type tok_chain [SLOTS+1];
   osb_pkg::emit_type  emit_vec  [SLOTS];
   osb_pkg::token_type tail_ff, tail_in;
   logic               advance;

   // Pending fired slot, held until we know whether it is the final one.
   logic                        pend_valid_ff, pend_valid_in;
   logic [osb_pkg::SLOT_W-1:0]  pend_id_ff, pend_id_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   osb_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [osb_pkg::SLOT_W-1:0]  rsp_id_ff, rsp_id_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        fire_any;
   logic [osb_pkg::SLOT_W-1:0]  fire_id;
   logic                        push_req, can_push, tail_done;
   osb_pkg::status_type         push_status;
   logic [osb_pkg::SLOT_W-1:0]  push_id;
   logic                        push_last;

   assign req_ch.ready = !busy_ff && !reset;
   assign accept       = req_ch.valid && req_ch.ready;

   // Inject the new item's token at the head of the chain.
   always_comb begin
      tok_chain[0]          = '0;
      tok_chain[0].valid    = accept;
      tok_chain[0].kind     = osb_pkg::kind_type'(req_ch.kind);
      tok_chain[0].slot     = req_ch.slot;
   end

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         osb_cell #(
            .IDX       (gi),
            .TIME_BITS (TIME_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .now_val   (now_ff),
            .arm_delay (dly_ff),
            .tok_prev  (tok_chain[gi]),
            .tok_next  (tok_chain[gi+1]),
            .emit      (emit_vec[gi])
         );
      end
   endgenerate

   // Only one token is in flight, so at most one cell fires per cycle.
   always_comb begin
      fire_any = 1'b0;
      fire_id  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         fire_any = fire_any | emit_vec[i].valid;
         fire_id  = fire_id | (emit_vec[i].valid ? emit_vec[i].id : '0);
      end
   end

   // Decide what, if anything, goes into the output register this cycle.
   always_comb begin
      push_req    = 1'b0;
      push_status = osb_pkg::STATUS_FIRED;
      push_id     = pend_id_ff;
      push_last   = 1'b0;
      priority if (tail_ff.valid) begin
         if (tail_ff.kind == osb_pkg::KIND_ARM) begin
            push_req    = 1'b1;
            push_status = tail_ff.claimed ? osb_pkg::STATUS_ARMED : osb_pkg::STATUS_NO_FREE;
            push_id     = tail_ff.claimed ? tail_ff.claim_id : '0;
            push_last   = 1'b1;
         end else if (pend_valid_ff) begin
            // Final fired slot of this tick.
            push_req  = 1'b1;
            push_last = 1'b1;
         end
      end else if (fire_any && pend_valid_ff) begin
         // A later slot fired, so the pending one is not the final result.
         push_req = 1'b1;
      end else begin
         push_req = 1'b0;
      end
   end

   assign can_push  = !rsp_valid_ff || rsp_ch.ready;
   assign advance   = !push_req || can_push;
   assign tail_done = tail_ff.valid && advance;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail_done) begin
         busy_in = 1'b0;
      end

      now_in = now_ff;
      dly_in = dly_ff;
      if (accept) begin
         dly_in = TIME_BITS'(req_ch.delay);
         if (osb_pkg::kind_type'(req_ch.kind) == osb_pkg::KIND_TICK) begin
            now_in = now_ff + TIME_BITS'(1);
         end
      end

      tail_in = advance ? tok_chain[SLOTS] : tail_ff;

      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      if (tail_done) begin
         pend_valid_in = 1'b0;
      end else if (advance && fire_any) begin
         pend_valid_in = 1'b1;
         pend_id_in    = fire_id;
      end

      // Output register: load on push, drop after the transfer.
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push_req && can_push) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = push_status;
         rsp_id_in     = push_id;
         rsp_last_in   = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         now_ff        <= '0;
         tail_ff.valid <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         now_ff        <= now_in;
         tail_ff       <= tail_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      dly_ff        <= dly_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.slot_id = rsp_id_ff;
   assign rsp_ch.last    = rsp_last_ff;

endmodule

// File: hdl/osb_cell.sv
// One timer slot of the bank: active flag, start time and delay, plus the
// token stage that passes the current item on. Depends on osb_pkg.
module osb_cell #(
   parameter int IDX       = 0,
   parameter int TIME_BITS = osb_pkg::TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [TIME_BITS-1:0]  now_val,
   input  logic [TIME_BITS-1:0]  arm_delay,
   input  osb_pkg::token_type    tok_prev,
   output osb_pkg::token_type    tok_next,
   output osb_pkg::emit_type     emit
);

   localparam logic [osb_pkg::SLOT_W-1:0] MY_ID = osb_pkg::SLOT_W'(IDX);
   localparam bit ADDRESSABLE = (IDX < (1 << osb_pkg::SLOT_W));

   osb_pkg::token_type   tok_ff, tok_in;
   logic                 active_ff, active_in;
   logic [TIME_BITS-1:0] start_ff, delay_ff;

   logic expired, arm_take, cancel_hit, fire, flush_hit;

   always_comb begin
      expired    = active_ff && ((now_val - start_ff) >= delay_ff);
      arm_take   = tok_ff.valid && (tok_ff.kind == osb_pkg::KIND_ARM)
                   && !tok_ff.claimed && !active_ff;
      cancel_hit = tok_ff.valid && (tok_ff.kind == osb_pkg::KIND_CANCEL)
                   && ADDRESSABLE && (tok_ff.slot == MY_ID);
      fire       = tok_ff.valid && (tok_ff.kind == osb_pkg::KIND_TICK) && expired
                   && (tok_ff.fire_cnt < osb_pkg::FIRE_LIMIT);
      flush_hit  = tok_ff.valid && (tok_ff.kind == osb_pkg::KIND_FLUSH) && expired;
   end

   always_comb begin
      tok_next = tok_ff;
      if (arm_take) begin
         tok_next.claimed  = 1'b1;
         tok_next.claim_id = MY_ID;
      end
      if (fire) begin
         tok_next.fire_cnt = tok_ff.fire_cnt + osb_pkg::FIRE_CNT_W'(1);
      end
      emit.valid = fire;
      emit.id    = MY_ID;
   end

   always_comb begin
      tok_in    = advance ? tok_prev : tok_ff;
      active_in = active_ff;
      if (advance) begin
         if (arm_take) begin
            active_in = 1'b1;
         end else if (cancel_hit || fire || flush_hit) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         tok_ff    <= tok_in;
         active_ff <= active_in;
      end
   end

   // Slot payload: written on arm only, no reset.
   always_ff @(posedge clock) begin
      if (advance && arm_take) begin
         start_ff <= now_val;
         delay_ff <= arm_delay;
      end
   end

endmodule

// File: hdl/osb_checker.sv
// Port-level checks for the one-shot timer bank, attached by bind.
// Depends on osb_pkg and one_shot_timer_bank_top.
module osb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [osb_pkg::SLOT_W-1:0]  rsp_slot_id,
   input logic                        rsp_last
);

   // Hold a stalled result steady.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_id) && $stable(rsp_last))
      else $error("stalled result changed");

   // One item at a time: a transfer closes the intake for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("intake open right after a transfer");

   // Arm results are always the only result of their item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != 2'(osb_pkg::STATUS_FIRED)) |-> rsp_last)
      else $error("arm result without last");

   // A full bank reports slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == 2'(osb_pkg::STATUS_NO_FREE)) |-> (rsp_slot_id == '0))
      else $error("no-free result with nonzero slot");

endmodule

bind one_shot_timer_bank_top osb_checker u_osb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_status  (rsp_ch.status),
   .rsp_slot_id (rsp_ch.slot_id),
   .rsp_last    (rsp_ch.last)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for one_shot_timer_bank_top: a directed opening, then random
// arm, cancel, tick and flush commands. Depends on osb_pkg, osb_if and the block RTL.
module tb_top;
   import osb_pkg::*;

   localparam int NUM_SLOTS   = SLOTS_DEFAULT;
   localparam int TIME_W      = TIME_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 250000;
   // Room for one item to walk the chain and the tail stage, with slack.
   localparam int SETTLE      = 4 * (NUM_SLOTS + 1);
   localparam int RAND_CMDS   = 124;

   // One command for the timer bank, with the idle time that precedes it.
   typedef struct {
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
      logic [DELAY_W-1:0] delay;
      int                gap;
      bit                drain;
   } timer_cmd_type;

   // One report leaving the bank.
   typedef struct {
      status_type        status;
      logic [SLOT_W-1:0] slot_id;
      logic              last;
   } timer_report_type;

   logic clock;
   logic reset;

   osb_req_if req_bus ();
   osb_rsp_if rsp_bus ();

   one_shot_timer_bank_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Commands waiting to be driven, and reports the bank owes us.
   timer_cmd_type    timer_cmds[$];
   timer_report_type owed_reports[$];

   // Shadow copy of the timer bank.
   bit                slot_busy [NUM_SLOTS];
   logic [TIME_W-1:0] armed_at  [NUM_SLOTS];
   logic [TIME_W-1:0] wait_ticks[NUM_SLOTS];
   logic [TIME_W-1:0] tick_count;

   int errors;
   int cycles;
   int n_armed, n_no_free, n_fired, n_cancel, n_flush, n_tick, max_burst;

   // Transfer flags, sampled at the rising edge and read by the falling-edge drivers.
   bit req_took;
   bit rsp_took;
   int gap_left;
   int stall_left;
   int rsp_seen;
   timer_cmd_type    next_cmd;
   timer_report_type head_report;

   // Apply one accepted command to the shadow bank and queue the reports it owes.
   task automatic timer_bank_apply(input timer_cmd_type c);
      int            fired;
      bit            found;
      logic [TIME_W-1:0] elapsed;
      timer_report_type rep;
      fired = 0;
      found = 1'b0;
      case (c.kind)
         KIND_ARM: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (!found && !slot_busy[s]) begin
                  found         = 1'b1;
                  slot_busy[s]  = 1'b1;
                  armed_at[s]   = tick_count;
                  wait_ticks[s] = TIME_W'(c.delay);
                  rep.status    = STATUS_ARMED;
                  rep.slot_id   = SLOT_W'(s);
                  rep.last      = 1'b1;
                  owed_reports.insert(owed_reports.size(), rep);
                  n_armed++;
               end
            end
            if (!found) begin
               rep.status  = STATUS_NO_FREE;
               rep.slot_id = '0;
               rep.last    = 1'b1;
               owed_reports.insert(owed_reports.size(), rep);
               n_no_free++;
            end
         end
         KIND_CANCEL: begin
            // Slot numbers past the bank are dropped; freeing a free slot is harmless.
            if (int'(c.slot) < NUM_SLOTS) slot_busy[c.slot] = 1'b0;
            n_cancel++;
         end
         KIND_TICK: begin
            tick_count = tick_count + 1'b1;
            for (int s = 0; s < NUM_SLOTS; s++) begin
               elapsed = tick_count - armed_at[s];
               if (fired < MAX_FIRES && slot_busy[s] && elapsed >= wait_ticks[s]) begin
                  slot_busy[s] = 1'b0;
                  rep.status   = STATUS_FIRED;
                  rep.slot_id  = SLOT_W'(s);
                  rep.last     = 1'b0;
                  owed_reports.insert(owed_reports.size(), rep);
                  fired++;
               end
            end
            // Mark the final report of this tick.
            if (fired > 0) owed_reports[owed_reports.size() - 1].last = 1'b1;
            n_fired += fired;
            if (fired > max_burst) max_burst = fired;
            n_tick++;
         end
         default: begin
            // Flush: drop expired slots silently, time holds still.
            for (int s = 0; s < NUM_SLOTS; s++) begin
               elapsed = tick_count - armed_at[s];
               if (slot_busy[s] && elapsed >= wait_ticks[s]) slot_busy[s] = 1'b0;
            end
            n_flush++;
         end
      endcase
   endtask

   task automatic add_cmd(input kind_type k, input int slot, input logic [DELAY_W-1:0] d,
                          input int gap, input bit drain);
      timer_cmd_type c;
      c.kind  = k;
      c.slot  = SLOT_W'(slot);
      c.delay = d;
      c.gap   = gap;
      c.drain = drain;
      timer_cmds.insert(timer_cmds.size(), c);
   endtask

   // Free-running clock, 12 ns period.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Rising edge: count cycles, predict every accepted command, check every report.
   always @(posedge clock) begin
      cycles++;
      req_took = req_bus.valid && req_bus.ready && !reset;
      rsp_took = rsp_bus.valid && rsp_bus.ready && !reset;
      if (req_took) begin
         next_cmd.kind  = kind_type'(req_bus.kind);
         next_cmd.slot  = req_bus.slot;
         next_cmd.delay = req_bus.delay;
         timer_bank_apply(next_cmd);
      end
      if (rsp_took) begin
         rsp_seen++;
         if (owed_reports.size() == 0) begin
            errors++;
            $display("%0t: report with none owed: status=%0d slot_id=%0d last=%0d",
                     $time, rsp_bus.status, rsp_bus.slot_id, rsp_bus.last);
         end else begin
            head_report = owed_reports.pop_front();
            if (rsp_bus.status !== head_report.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time,
                        head_report.status, rsp_bus.status);
            end
            if (rsp_bus.slot_id !== head_report.slot_id) begin
               errors++;
               $display("%0t: slot_id expected %0d actual %0d", $time,
                        head_report.slot_id, rsp_bus.slot_id);
            end
            if (rsp_bus.last !== head_report.last) begin
               errors++;
               $display("%0t: last expected %0d actual %0d", $time,
                        head_report.last, rsp_bus.last);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Command driver: hold a command until its transfer, idle for the next command's
   // gap, and hold off a draining command until every owed report has arrived.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = (timer_cmds.size() != 0) ? timer_cmds[0].gap : 0;
      end else begin
         if (req_took) gap_left = (timer_cmds.size() != 0) ? timer_cmds[0].gap : 0;
         if (req_bus.valid && !req_took) begin
            // hold the current command
         end else if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
         end else if (timer_cmds.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (timer_cmds[0].drain && owed_reports.size() != 0) begin
            req_bus.valid <= 1'b0;
         end else begin
            next_cmd = timer_cmds.pop_front();
            req_bus.kind  <= next_cmd.kind;
            req_bus.slot  <= next_cmd.slot;
            req_bus.delay <= next_cmd.delay;
            req_bus.valid <= 1'b1;
         end
      end
   end

   // Report sink: after each transfer draw a random stall; for 12 reports out of
   // every 48, ready is held high throughout.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_took) stall_left = ((rsp_seen % 48) < 12) ? 0 : $urandom_range(0, 17);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int r;
      int pick;
      int gap;
      logic [DELAY_W-1:0] d;

      // Drive every input to a known value before the first edge.
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_ARM;
      req_bus.slot  = '0;
      req_bus.delay = '0;
      rsp_bus.ready = 1'b0;
      errors        = 0;
      cycles        = 0;
      tick_count    = '0;
      for (int s = 0; s < NUM_SLOTS; s++) slot_busy[s] = 1'b0;

      // Directed opening: empty tick, delay extremes, cancel of a free slot,
      // a flush that keeps a long timer, a full bank, arm with no free slot,
      // and a tick that fires all sixteen slots at once.
      add_cmd(KIND_TICK,   9,  32'h0,        0, 1'b0);
      add_cmd(KIND_ARM,    0,  32'h0,        2, 1'b0);
      add_cmd(KIND_ARM,    6,  32'hFFFF_FFFF, 0, 1'b0);
      add_cmd(KIND_CANCEL, 15, 32'h0,        1, 1'b0);
      add_cmd(KIND_TICK,   0,  32'hFFFF_FFFF, 0, 1'b0);
      add_cmd(KIND_FLUSH,  5,  32'h0,        3, 1'b0);
      add_cmd(KIND_CANCEL, 1,  32'h0,        0, 1'b0);
      add_cmd(KIND_ARM,    10, 32'h0,        0, 1'b1);
      add_cmd(KIND_FLUSH,  0,  32'h0,        0, 1'b0);
      for (int i = 0; i < NUM_SLOTS; i++)
         add_cmd(KIND_ARM, i, (i % 2) ? 32'h0 : 32'h1, (i < 8) ? 0 : 5, 1'b0);
      add_cmd(KIND_ARM,    3,  32'h5,        0, 1'b0);
      add_cmd(KIND_TICK,   12, 32'h0,        0, 1'b0);

      // Random part: mostly arms and ticks with short delays so timers fire,
      // some wide delays that park slots, cancels and flushes to free them.
      for (int i = 0; i < RAND_CMDS; i++) begin
         r = $urandom_range(0, 99);
         pick = $urandom_range(0, 9);
         if (pick <= 5)      d = $urandom_range(0, 6);
         else if (pick <= 7) d = $urandom_range(0, 40);
         else if (pick == 8) d = $urandom;
         else                d = '0;
         // Alternate stretches of random gaps and back-to-back commands.
         gap = ((i / 25) % 2) ? 0 : $urandom_range(0, 17);
         add_cmd((r < 35) ? KIND_ARM : (r < 70) ? KIND_TICK : (r < 85) ? KIND_CANCEL
                 : KIND_FLUSH, $urandom_range(0, 15), d, gap, (i == 50) || (i == 110));
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last transfer, then for every owed report, then let the
      // chain and the output stage settle so stray reports show up.
      while (timer_cmds.size() != 0 || req_bus.valid) @(posedge clock);
      while (owed_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (owed_reports.size() != 0) begin
         errors++;
         $display("%0t: %0d reports never arrived", $time, owed_reports.size());
      end

      $display("Covered %0d arms, %0d with no free slot, %0d ticks firing %0d timers",
               n_armed, n_no_free, n_tick, n_fired);
      $display("(largest burst %0d), %0d cancels, %0d flushes; %0d errors.",
               max_burst, n_cancel, n_flush, errors);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
